>>> rtl/core/lps_pkg.sv
// Shared types, constants and pattern table for the LED pattern sequencer.
package lps_pkg;

   localparam int CMD_W   = 3;
   localparam int PAT_W   = 3;
   localparam int STEP_W  = 4;
   localparam int TIMER_W = 8;
   localparam int CHAN_W  = 2;
   localparam int OUT_W   = 2;

   localparam logic REQ_POST = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [CMD_W-1:0]   CMD_DARK      = 3'd0;
   localparam logic [CMD_W-1:0]   CMD_UNKNOWN   = 3'd7;
   localparam logic [PAT_W-1:0]   PAT_DARK      = 3'd0;
   localparam logic [STEP_W-1:0]  LOOP_TARGET   = 4'd0;
   localparam logic [TIMER_W-1:0] RESET_TIMER   = 8'd10;

   typedef struct packed {
      logic             fire;
      logic             tick;
      logic             post;
      logic             clear_first;
      logic [CMD_W-1:0] command;
   } ctrl_type;

   typedef struct packed {
      logic level_now;
      logic level_next;
      logic busy_next;
      logic drop;
   } stat_type;

   function automatic logic [STEP_W-1:0] pat_steps(input logic [PAT_W-1:0] pat);
      logic [STEP_W-1:0] n;
      case (pat)
         3'd2, 3'd3, 3'd5, 3'd6: n = 4'd2;
         3'd4:                   n = 4'd6;
         default:                n = 4'd1;
      endcase
      return n;
   endfunction

   function automatic logic pat_loops(input logic [PAT_W-1:0] pat);
      logic l;
      case (pat)
         3'd3, 3'd4, 3'd5, 3'd6: l = 1'b1;
         default:                l = 1'b0;
      endcase
      return l;
   endfunction

   function automatic logic pat_level(input logic [PAT_W-1:0] pat,
                                      input logic [STEP_W-1:0] step);
      logic l;
      case (pat)
         3'd1:                   l = 1'b1;
         3'd2, 3'd3, 3'd5, 3'd6: l = (step == 4'd0);
         3'd4:                   l = ~step[0];
         default:                l = 1'b0;
      endcase
      return l;
   endfunction

   function automatic logic [TIMER_W-1:0] pat_dur(input logic [PAT_W-1:0] pat,
                                                  input logic [STEP_W-1:0] step);
      logic [TIMER_W-1:0] d;
      case (pat)
         3'd4:    d = (step == 4'd5) ? 8'd200 : 8'd10;
         3'd5:    d = 8'd30;
         3'd6:    d = 8'd50;
         default: d = 8'd10;
      endcase
      return d;
   endfunction

endpackage

>>> rtl/core/lps_req_if.sv
// Request channel interface: effect posts and timer ticks.
interface lps_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [lps_pkg::CHAN_W-1:0]   channel;
   logic [lps_pkg::CMD_W-1:0]    command;
   logic                         clear_first;

   modport source (output valid, req_type, channel, command, clear_first, input ready);
   modport sink   (input valid, req_type, channel, command, clear_first, output ready);
endinterface

>>> rtl/core/lps_rsp_if.sv
// Response channel interface: channel levels, busy mask and drop flag.
interface lps_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lps_pkg::OUT_W-1:0]   levels;
   logic [lps_pkg::OUT_W-1:0]   busy_mask;
   logic                        dropped;

   modport source (output valid, levels, busy_mask, dropped, input ready);
   modport sink   (input valid, levels, busy_mask, dropped, output ready);
endinterface

>>> rtl/core/led_pattern_sequencer_unit.sv
// Top level of the LED pattern sequencer: request register, channels, response register.
//
//   channel   direction  transfer moves
//   req_if    in         req_type, channel, command, clear_first
//   rsp_if    out        levels, busy_mask, dropped
//
// One request is taken every cycle unless a stalled response has filled both registers;
// its response passes through the request register and then the response register.
// The channel state is updated in the same edge that loads the response.
// A stalled response holds the request register, and req_if.ready falls only
// when both registers are full. The command queues need no clearing since
// their entries are only read after being written.
module led_pattern_sequencer_unit #(
   parameter int CHANNELS    = 2,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   lps_req_if.sink   req_if,
   lps_rsp_if.source rsp_if
);

   localparam int CMP_W = ($clog2(CHANNELS) > lps_pkg::CHAN_W) ?
                          $clog2(CHANNELS) : lps_pkg::CHAN_W;

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_type_ff;
   logic [lps_pkg::CHAN_W-1:0]   s1_channel_ff;
   logic [lps_pkg::CMD_W-1:0]    s1_command_ff;
   logic                         s1_clear_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lps_pkg::OUT_W-1:0]    rsp_levels_ff;
   logic [lps_pkg::OUT_W-1:0]    rsp_busy_ff;
   logic                         rsp_dropped_ff;

   logic                         out_free;
   logic                         fire;
   logic                         req_accept;
   logic [lps_pkg::OUT_W-1:0]    levels_next;
   logic [lps_pkg::OUT_W-1:0]    busy_next;
   logic [lps_pkg::OUT_W-1:0]    levels_now;
   logic                         drop_any;

   lps_pkg::ctrl_type            ctrl [CHANNELS];
   lps_pkg::stat_type            stat [CHANNELS];

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign fire         = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || out_free;
   assign req_accept   = req_if.valid && req_if.ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_type_ff    <= req_if.req_type;
         s1_channel_ff <= req_if.channel;
         s1_command_ff <= req_if.command;
         s1_clear_ff   <= req_if.clear_first;
      end
      if (fire) begin
         rsp_levels_ff  <= levels_next;
         rsp_busy_ff    <= busy_next;
         rsp_dropped_ff <= drop_any;
      end
   end

   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      assign ctrl[i].fire        = fire;
      assign ctrl[i].tick        = fire && (s1_type_ff == lps_pkg::REQ_TICK);
      assign ctrl[i].post        = fire && (s1_type_ff == lps_pkg::REQ_POST) &&
                                   (CMP_W'(s1_channel_ff) == CMP_W'(i));
      assign ctrl[i].clear_first = s1_clear_ff;
      assign ctrl[i].command     = s1_command_ff;

      lps_channel #(
         .QUEUE_DEPTH (QUEUE_DEPTH)
      ) u_channel (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl[i]),
         .stat  (stat[i])
      );
   end

   // Only the first two channels appear in the response.
   for (genvar b = 0; b < lps_pkg::OUT_W; b++) begin : g_out
      if (b < CHANNELS) begin : g_used
         assign levels_next[b] = stat[b].level_next;
         assign busy_next[b]   = stat[b].busy_next;
         assign levels_now[b]  = stat[b].level_now;
      end else begin : g_unused
         assign levels_next[b] = 1'b0;
         assign busy_next[b]   = 1'b0;
         assign levels_now[b]  = 1'b0;
      end
   end

   always_comb begin
      drop_any = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         drop_any = drop_any | stat[i].drop;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.levels    = rsp_levels_ff;
   assign rsp_if.busy_mask = rsp_busy_ff;
   assign rsp_if.dropped   = rsp_dropped_ff;

   // A post never moves the driven levels.
   a_post_holds_levels: assert property (@(posedge clock) disable iff (reset)
      (fire && (s1_type_ff == lps_pkg::REQ_POST)) |-> (levels_next == levels_now))
      else $error("post changed the driven levels");

   // A tick never reports a dropped command.
   a_tick_no_drop: assert property (@(posedge clock) disable iff (reset)
      (fire && (s1_type_ff == lps_pkg::REQ_TICK)) |=> !rsp_dropped_ff)
      else $error("tick reported a dropped command");

   // No request is processed while the response register is stalled.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |-> !fire)
      else $error("request processed into a stalled response register");

   // With the request register empty, a new transfer is always possible.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_if.ready)
      else $error("request channel stalled with an empty request register");

endmodule

>>> rtl/core/lps_channel.sv
// One sequencer channel: command queue, pattern stepping and effect loading.
module lps_channel #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  lps_pkg::ctrl_type ctrl,
   output lps_pkg::stat_type stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

   logic [lps_pkg::CMD_W-1:0]   queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]            head_ff, head_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [lps_pkg::PAT_W-1:0]   pattern_ff, pattern_in;
   logic [lps_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [lps_pkg::TIMER_W-1:0] timer_ff, timer_in;
   logic                        busy_ff, busy_in;
   logic                        level_ff, level_in;

   logic                        wr_en;
   logic [PTR_W-1:0]            wr_pos;
   logic                        drop;

   always_comb begin
      logic [lps_pkg::STEP_W-1:0]  steps;
      logic [lps_pkg::STEP_W-1:0]  s_cur;
      logic [lps_pkg::STEP_W-1:0]  s_new;
      logic [lps_pkg::TIMER_W-1:0] t_dec;
      logic [SUM_W-1:0]            sum;
      logic [lps_pkg::CMD_W-1:0]   ld_cmd;

      head_in    = head_ff;
      count_in   = count_ff;
      pattern_in = pattern_ff;
      step_in    = step_ff;
      timer_in   = timer_ff;
      busy_in    = busy_ff;
      level_in   = level_ff;
      wr_en      = 1'b0;
      wr_pos     = '0;
      drop       = 1'b0;
      sum        = '0;
      ld_cmd     = lps_pkg::CMD_DARK;

      // Tick: count down and advance through the pattern table.
      steps = lps_pkg::pat_steps(pattern_ff);
      s_cur = (step_ff >= steps) ? steps - 4'd1 : step_ff;
      t_dec = (timer_ff != '0) ? timer_ff - 8'd1 : timer_ff;
      s_new = s_cur;
      if (ctrl.tick) begin
         timer_in = t_dec;
         if (t_dec == '0) begin
            if (s_cur + 4'd1 >= steps) begin
               if (lps_pkg::pat_loops(pattern_ff)) begin
                  s_new    = lps_pkg::LOOP_TARGET;
                  timer_in = lps_pkg::pat_dur(pattern_ff, s_new);
               end else begin
                  busy_in = 1'b0;
               end
            end else begin
               s_new    = s_cur + 4'd1;
               timer_in = lps_pkg::pat_dur(pattern_ff, s_new);
            end
            step_in = s_new;
         end
         level_in = lps_pkg::pat_level(pattern_ff, s_new);
      end

      // Post: optional flush, then append unless the queue is full.
      if (ctrl.post) begin
         if (ctrl.clear_first) begin
            head_in  = '0;
            count_in = '0;
            busy_in  = 1'b0;
         end
         if (count_in == FULL_CNT) begin
            drop = 1'b1;
         end else begin
            sum      = SUM_W'(head_in) + SUM_W'(count_in);
            if (sum >= DEPTH_SUM) begin
               sum = sum - DEPTH_SUM;
            end
            wr_en    = 1'b1;
            wr_pos   = sum[PTR_W-1:0];
            count_in = count_in + CNT_W'(1);
         end
      end

      // Load: a free channel takes its oldest queued command. The entry
      // written by this very transfer is forwarded from the request.
      if (ctrl.fire && (count_in != '0) && !busy_in) begin
         ld_cmd   = (wr_en && (wr_pos == head_in)) ? ctrl.command : queue_ff[head_in];
         head_in  = (head_in == LAST_PTR) ? '0 : head_in + PTR_W'(1);
         count_in = count_in - CNT_W'(1);
         busy_in  = 1'b1;
         if (ld_cmd != lps_pkg::CMD_UNKNOWN) begin
            pattern_in = ld_cmd;
            step_in    = '0;
            timer_in   = lps_pkg::pat_dur(ld_cmd, 4'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_ff[wr_pos] <= ctrl.command;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         pattern_ff <= lps_pkg::PAT_DARK;
         step_ff    <= '0;
         timer_ff   <= lps_pkg::RESET_TIMER;
         busy_ff    <= 1'b1;
         level_ff   <= 1'b0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         pattern_ff <= pattern_in;
         step_ff    <= step_in;
         timer_ff   <= timer_in;
         busy_ff    <= busy_in;
         level_ff   <= level_in;
      end
   end

   assign stat.level_now  = level_ff;
   assign stat.level_next = level_in;
   assign stat.busy_next  = busy_in;
   assign stat.drop       = drop;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the LED pattern sequencer: directed table, random posts and ticks.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CH = 2;
   localparam int QDEPTH = 4;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int CH_BITS   = lps_pkg::CHAN_W;
   localparam int STEP_BITS = lps_pkg::STEP_W;
   localparam int TIME_BITS = lps_pkg::TIMER_W;

   typedef enum logic [lps_pkg::CMD_W-1:0] {
      FX_DARK = lps_pkg::CMD_DARK, FX_LIGHT, FX_SHORT, FX_BLINK, FX_TRIPLE, FX_SLOW, FX_LAZY,
      FX_UNKNOWN
   } fx_cmd_type;

   typedef struct packed {
      logic               kind;
      logic [CH_BITS-1:0] chan;
      fx_cmd_type         cmd;
      logic               clr;
   } effect_req_type;

   typedef struct packed {
      logic [lps_pkg::OUT_W-1:0] levels;
      logic [lps_pkg::OUT_W-1:0] busy;
      logic                      dropped;
   } status_type;

   typedef struct packed {
      logic                      kind;
      logic [CH_BITS-1:0]        chan;
      fx_cmd_type                cmd;
      logic                      clr;
      logic [7:0]                reps;
      logic                      known;
      logic [lps_pkg::OUT_W-1:0] want_levels;
      logic [lps_pkg::OUT_W-1:0] want_busy;
      logic                      want_drop;
   } plan_row_type;

   // Effect table: number of steps, loop flag, and the level and duration of each step.
   localparam int FX_STEPS [7] = '{1, 1, 2, 2, 6, 2, 2};
   localparam bit FX_LOOPS [7] = '{0, 0, 0, 1, 1, 1, 1};
   localparam bit FX_LEVEL [7][6] = '{
      '{0, 0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0, 0},
      '{1, 0, 1, 0, 1, 0}, '{1, 0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0, 0}};
   localparam int FX_DUR [7][6] = '{
      '{10, 0, 0, 0, 0, 0}, '{10, 0, 0, 0, 0, 0}, '{10, 10, 0, 0, 0, 0},
      '{10, 10, 0, 0, 0, 0}, '{10, 10, 10, 10, 10, 200}, '{30, 30, 0, 0, 0, 0},
      '{50, 50, 0, 0, 0, 0}};

   plan_row_type directed_plan [15] = '{
      '{lps_pkg::REQ_POST, 2'd0, FX_LIGHT,   1'b0, 8'd1, 1'b1, 2'b00, 2'b11, 1'b0},
      '{lps_pkg::REQ_POST, 2'd0, FX_SHORT,   1'b0, 8'd1, 1'b1, 2'b00, 2'b11, 1'b0},
      '{lps_pkg::REQ_POST, 2'd0, FX_BLINK,   1'b0, 8'd1, 1'b1, 2'b00, 2'b11, 1'b0},
      '{lps_pkg::REQ_POST, 2'd0, FX_TRIPLE,  1'b0, 8'd1, 1'b1, 2'b00, 2'b11, 1'b0},
      '{lps_pkg::REQ_POST, 2'd0, FX_SLOW,    1'b0, 8'd1, 1'b1, 2'b00, 2'b11, 1'b1},
      '{lps_pkg::REQ_POST, 2'd2, FX_LAZY,    1'b0, 8'd1, 1'b1, 2'b00, 2'b11, 1'b0},
      '{lps_pkg::REQ_POST, 2'd3, FX_UNKNOWN, 1'b1, 8'd1, 1'b1, 2'b00, 2'b11, 1'b0},
      '{lps_pkg::REQ_POST, 2'd0, FX_LAZY,    1'b1, 8'd1, 1'b1, 2'b00, 2'b11, 1'b0},
      '{lps_pkg::REQ_POST, 2'd1, FX_UNKNOWN, 1'b1, 8'd1, 1'b1, 2'b00, 2'b11, 1'b0},
      '{lps_pkg::REQ_TICK, 2'd0, FX_DARK,    1'b0, 8'd1, 1'b0, 2'b00, 2'b00, 1'b0},
      '{lps_pkg::REQ_POST, 2'd1, FX_LIGHT,   1'b0, 8'd1, 1'b0, 2'b00, 2'b00, 1'b0},
      '{lps_pkg::REQ_TICK, 2'd3, FX_UNKNOWN, 1'b1, 8'd9, 1'b0, 2'b00, 2'b00, 1'b0},
      '{lps_pkg::REQ_POST, 2'd0, FX_DARK,    1'b1, 8'd1, 1'b0, 2'b00, 2'b00, 1'b0},
      '{lps_pkg::REQ_POST, 2'd1, FX_SHORT,   1'b0, 8'd1, 1'b0, 2'b00, 2'b00, 1'b0},
      '{lps_pkg::REQ_TICK, 2'd0, FX_DARK,    1'b0, 8'd3, 1'b0, 2'b00, 2'b00, 1'b0}};

   logic clock = 1'b0;
   logic reset;

   lps_req_if req_ch ();
   lps_rsp_if rsp_ch ();

   led_pattern_sequencer_unit #(
      .CHANNELS    (NUM_CH),
      .QUEUE_DEPTH (QDEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Predicted channel state.
   fx_cmd_type                  fx_queue   [NUM_CH][QDEPTH];
   int                          q_head     [NUM_CH];
   int                          q_count    [NUM_CH];
   logic [lps_pkg::PAT_W-1:0]   ch_pattern [NUM_CH];
   logic [STEP_BITS-1:0]        ch_step    [NUM_CH];
   logic [TIME_BITS-1:0]        ch_timer   [NUM_CH];
   logic                        ch_busy    [NUM_CH];
   logic                        ch_level   [NUM_CH];

   status_type expected_status [$];
   int      errors = 0;
   int      send_idle_pct;
   int      recv_idle_pct;
   bit      hold_requested = 1'b0;
   int      stall_left = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic status_type predict_status(input effect_req_type r);
      status_type s;
      int         st;
      fx_cmd_type cmd;
      s = '0;
      if (r.kind == lps_pkg::REQ_TICK) begin
         for (int c = 0; c < NUM_CH; c++) begin
            st = int'(ch_step[c]);
            if (st >= FX_STEPS[ch_pattern[c]]) st = FX_STEPS[ch_pattern[c]] - 1;
            if (ch_timer[c] != 0) ch_timer[c]--;
            if (ch_timer[c] == 0) begin
               if (st + 1 >= FX_STEPS[ch_pattern[c]]) begin
                  // End of the effect: loop back, or free the channel and hold the level.
                  if (FX_LOOPS[ch_pattern[c]]) begin
                     st = int'(lps_pkg::LOOP_TARGET);
                     ch_timer[c] = TIME_BITS'(FX_DUR[ch_pattern[c]][st]);
                  end else begin
                     ch_busy[c] = 1'b0;
                  end
               end else begin
                  st++;
                  ch_timer[c] = TIME_BITS'(FX_DUR[ch_pattern[c]][st]);
               end
               ch_step[c] = STEP_BITS'(st);
            end
            ch_level[c] = FX_LEVEL[ch_pattern[c]][st];
         end
      end else if (r.chan < NUM_CH) begin
         if (r.clr) begin
            q_count[r.chan] = 0;
            q_head[r.chan]  = 0;
            ch_busy[r.chan] = 1'b0;
         end
         if (q_count[r.chan] >= QDEPTH) begin
            s.dropped = 1'b1;
         end else begin
            fx_queue[r.chan][(q_head[r.chan] + q_count[r.chan]) % QDEPTH] = r.cmd;
            q_count[r.chan]++;
         end
      end
      for (int c = 0; c < NUM_CH; c++) begin
         if (q_count[c] != 0 && !ch_busy[c]) begin
            cmd        = fx_queue[c][q_head[c]];
            q_head[c]  = (q_head[c] + 1) % QDEPTH;
            q_count[c]--;
            ch_busy[c] = 1'b1;
            // An unknown command only marks the channel busy.
            if (cmd != FX_UNKNOWN) begin
               ch_pattern[c] = cmd;
               ch_step[c]    = '0;
               ch_timer[c]   = TIME_BITS'(FX_DUR[cmd][0]);
            end
         end
      end
      for (int c = 0; c < NUM_CH && c < lps_pkg::OUT_W; c++) begin
         s.levels[c] = ch_level[c];
         s.busy[c]   = ch_busy[c];
      end
      return s;
   endfunction

   task automatic offer_request(input effect_req_type item, input bit known,
                                input status_type want);
      bit         taken;
      status_type pred;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= item.kind;
      req_ch.channel     <= item.chan;
      req_ch.command     <= item.cmd;
      req_ch.clear_first <= item.clr;
      taken = 1'b0;
      while (!taken) begin
         // Sample ready between edges; the transfer happens at the next rising edge.
         @(negedge clock);
         taken = (req_ch.ready === 1'b1);
         if (taken) begin
            pred = predict_status(item);
            expected_status.push_back(known ? want : pred);
         end
         @(posedge clock);
      end
   endtask

   // Result side: random stalls, plus one long hold-off counted here.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requested) begin
            hold_requested = 1'b0;
            stall_left     = 80;
         end
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      bit         fire;
      status_type got;
      status_type want;
      forever begin
         @(negedge clock);
         fire = (rsp_ch.valid === 1'b1) && (rsp_ch.ready === 1'b1);
         got  = '{rsp_ch.levels, rsp_ch.busy_mask, rsp_ch.dropped};
         @(posedge clock);
         if (fire) begin
            if (expected_status.size() == 0) begin
               $error("unexpected result transfer: levels %0d, busy_mask %0d, dropped %0d",
                      got.levels, got.busy, got.dropped);
               errors++;
            end else begin
               want = expected_status.pop_front();
               if (got.levels !== want.levels) begin
                  $error("levels: expected %0d, got %0d", want.levels, got.levels);
                  errors++;
               end
               if (got.busy !== want.busy) begin
                  $error("busy_mask: expected %0d, got %0d", want.busy, got.busy);
                  errors++;
               end
               if (got.dropped !== want.dropped) begin
                  $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      #2ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      effect_req_type item;
      plan_row_type   row;
      int             clr_pct;
      int             roll;
      int             drain;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = lps_pkg::REQ_POST;
      req_ch.channel     = '0;
      req_ch.command     = lps_pkg::CMD_DARK;
      req_ch.clear_first = 1'b0;
      send_idle_pct      = 33;
      recv_idle_pct      = 49;
      for (int c = 0; c < NUM_CH; c++) begin
         q_head[c]     = 0;
         q_count[c]    = 0;
         ch_pattern[c] = lps_pkg::PAT_DARK;
         ch_step[c]    = '0;
         ch_timer[c]   = lps_pkg::RESET_TIMER;
         ch_busy[c]    = 1'b1;
         ch_level[c]   = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         row  = directed_plan[i];
         item = '{row.kind, row.chan, row.cmd, row.clr};
         repeat (row.reps)
            offer_request(item, row.known, '{row.want_levels, row.want_busy, row.want_drop});
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 49 : 0;
         recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 33 : 0;
         // Fewer flushes in the middle phase let the long effects run through their loops.
         clr_pct       = (phase == 1) ? 3 : 12;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 2 && n == 100) hold_requested = 1'b1;
            if (phase == 1 && n == 150) begin
               req_ch.valid <= 1'b0;
               while (expected_status.size() != 0) @(posedge clock);
            end
            roll      = $urandom_range(99);
            item.kind = (roll < 60) ? lps_pkg::REQ_TICK : lps_pkg::REQ_POST;
            item.chan = (roll < 93) ? CH_BITS'($urandom_range(1)) :
                                      CH_BITS'($urandom_range(3, 2));
            item.cmd  = fx_cmd_type'($urandom_range(7));
            item.clr  = ($urandom_range(99) < clr_pct);
            offer_request(item, 1'b0, '0);
         end
      end
      req_ch.valid <= 1'b0;

      drain = 0;
      while (expected_status.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (expected_status.size() != 0) begin
         $error("%0d expected results never arrived", expected_status.size());
         errors++;
      end
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/lps_pkg.sv
rtl/core/lps_req_if.sv
rtl/core/lps_rsp_if.sv
rtl/core/lps_channel.sv
rtl/core/led_pattern_sequencer_unit.sv
tb/testbench.sv
